// ===== design/weighted_rr_run_queue_defines.svh =====
// assertion macros for the weighted round-robin run queue checker
// no dependencies
`ifndef WEIGHTED_RR_RUN_QUEUE_DEFINES_SVH
`define WEIGHTED_RR_RUN_QUEUE_DEFINES_SVH

// clocked property, ignored while reset is held
`define WRQ_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// clocked property, also checked during reset
`define WRQ_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/wrq_pkg.sv =====
// shared constants, codes and types of the weighted round-robin run queue
// no dependencies
package wrq_pkg;

  localparam int MAX_TASKS   = 64;
  localparam int SLICE_TICKS = 10;
  localparam int ID_W        = 6;
  localparam int NUM_IDS     = 2 ** ID_W;
  localparam int POS_W       = $clog2(MAX_TASKS);
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int W_W         = 8;
  localparam int SLICE_W     = 12;
  localparam int SUM_W       = 14;
  localparam int STATUS_W    = 2;
  localparam int KIND_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int RAM_W       = W_W + SLICE_W;

  localparam int IN_DATA_W   = 8;
  localparam int IN_TASK_LO  = 0;
  localparam int IN_FG_BIT   = 6;

  localparam int OUT_DATA_W    = 48;
  localparam int OUT_STATUS_LO = 0;
  localparam int OUT_RESCHED   = 2;
  localparam int OUT_NVALID    = 3;
  localparam int OUT_NTASK_LO  = 4;
  localparam int OUT_SUM_LO    = 10;
  localparam int OUT_CNT_LO    = 24;
  localparam int OUT_SLICE_LO  = 31;
  localparam int OUT_PAD_W     = OUT_DATA_W - (OUT_SLICE_LO + SLICE_W);

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_WEIGHT = 3'd0,
    KIND_ENQUEUE    = 3'd1,
    KIND_DEQUEUE    = 3'd2,
    KIND_TICK       = 3'd3,
    KIND_YIELD      = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_QUEUED = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_WEIGHT = 1'b0,
    CFG_BG_WEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_DONE
  } fsm_state_t;

  // control broadcast from the sequencer to every cell of the queue row
  typedef struct packed {
    logic             match_en;
    logic [ID_W-1:0]  cmp_id;
    logic [CNT_W-1:0] count;
    logic             shift_en;
    logic [POS_W-1:0] pos;
    logic             load_en;
    logic [POS_W-1:0] load_pos;
    logic [ID_W-1:0]  load_id;
  } cell_ctl_t;

endpackage

// ===== design/weighted_rr_run_queue.sv =====
// weighted round-robin run queue: a sequencer over a row of queue cells
// result: registered in the done state after look and exec, held until out_tready
// a new transaction is taken only in idle, once the four-step sequencer
// (table lookup, table and totals update, chain shift, result report) has finished
// reset: synchronous active low; empties the queue, zeroes all task weights and
// slices at once, restores weights to 10 (foreground) and 1 (background)
module weighted_rr_run_queue
  import wrq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [W_W-1:0]        cfg_data,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // task_id[5:0], foreground[6], zero pad[7]
  input  logic [KIND_W-1:0]     in_tuser,   // kind[2:0]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], need_resched[2],
                                            // next_valid[3], next_task[9:4],
                                            // weight_sum[23:10], queued_count[30:24],
                                            // slice_remaining[42:31], zero pad[47:43]
);

  fsm_state_t state_r, state_nxt;

  logic [W_W-1:0]     fg_weight_r, bg_weight_r;
  logic [KIND_W-1:0]  kind_r;
  logic [ID_W-1:0]    task_r;
  logic               fg_r;

  logic [NUM_IDS-1:0] qmark_r;
  logic [NUM_IDS-1:0] wvld_r;
  logic [SUM_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                resched_r, resched_nxt;
  logic                shift_r, shift_nxt;
  logic                load_r, load_nxt;
  logic [POS_W-1:0]    load_pos_r, load_pos_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [SLICE_W-1:0]  slice_r, slice_nxt;
  logic                qset, qclr;

  logic                  ram_we;
  logic                  wr_en;
  logic [W_W-1:0]        wr_w;
  logic [RAM_W-1:0]      ram_q;
  logic [W_W-1:0]        cur_w, cfg_w;
  logic [SLICE_W-1:0]    cur_s, fresh;
  logic [CNT_W-1:0]      cnt_dec;
  logic                  queued;

  logic                  in_accept;
  logic                  out_load;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  cell_ctl_t             ctl;
  logic [ID_W-1:0]       head_id;
  logic [POS_W-1:0]      match_pos;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_weight_r <= W_W'(10);
      bg_weight_r <= W_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FG_WEIGHT: fg_weight_r <= cfg_data;
        CFG_BG_WEIGHT: bg_weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- per-task table
  wrq_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_IDS)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (task_r),
    .wdata ({wr_w, slice_nxt}),
    .raddr (in_tdata[IN_TASK_LO +: ID_W]),
    .rdata (ram_q)
  );

  // an entry never written reads as weight 0, slice 0
  assign cur_w   = wvld_r[task_r] ? ram_q[SLICE_W +: W_W] : '0;
  assign cur_s   = wvld_r[task_r] ? ram_q[0 +: SLICE_W] : '0;
  assign cfg_w   = fg_r ? fg_weight_r : bg_weight_r;
  assign fresh   = SLICE_W'(cur_w * SLICE_TICKS);
  assign queued  = qmark_r[task_r];
  assign cnt_dec = count_r - CNT_W'(1);
  assign ram_we  = (state_r == S_LOOK) && wr_en;

  // ---------------------------------------------------------------- operation decode
  always_comb begin
    status_nxt   = ST_DONE;
    resched_nxt  = 1'b0;
    shift_nxt    = 1'b0;
    load_nxt     = 1'b0;
    load_pos_nxt = count_r[POS_W-1:0];
    slice_nxt    = cur_s;
    wr_en        = 1'b0;
    wr_w         = cur_w;
    total_nxt    = total_r;
    count_nxt    = count_r;
    qset         = 1'b0;
    qclr         = 1'b0;
    case (kind_r)
      KIND_SET_WEIGHT: begin
        wr_en     = 1'b1;
        wr_w      = cfg_w;
        slice_nxt = SLICE_W'(cfg_w);
        if (queued) begin
          total_nxt = total_r - SUM_W'(cur_w) + SUM_W'(cfg_w);
        end
      end
      KIND_ENQUEUE: begin
        if (queued) begin
          status_nxt = ST_QUEUED;
        end else if (count_r >= CNT_W'(MAX_TASKS)) begin
          status_nxt = ST_FULL;
        end else begin
          load_nxt  = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          qset      = 1'b1;
          slice_nxt = fresh;
          wr_en     = 1'b1;
          total_nxt = total_r + SUM_W'(cur_w);
        end
      end
      KIND_DEQUEUE: begin
        if (!queued) begin
          status_nxt = ST_ABSENT;
        end else begin
          shift_nxt = 1'b1;
          count_nxt = cnt_dec;
          qclr      = 1'b1;
          slice_nxt = '0;
          wr_en     = 1'b1;
          total_nxt = total_r - SUM_W'(cur_w);
        end
      end
      KIND_TICK: begin
        if (!queued) begin
          status_nxt = ST_ABSENT;
        end else if (cur_s <= SLICE_W'(1)) begin
          // slice used up: rotate to the tail
          shift_nxt    = 1'b1;
          load_nxt     = 1'b1;
          load_pos_nxt = cnt_dec[POS_W-1:0];
          slice_nxt    = fresh;
          resched_nxt  = 1'b1;
          wr_en        = 1'b1;
        end else begin
          slice_nxt = cur_s - SLICE_W'(1);
          wr_en     = 1'b1;
        end
      end
      KIND_YIELD: begin
        if (!queued) begin
          status_nxt = ST_ABSENT;
        end else begin
          shift_nxt    = 1'b1;
          load_nxt     = 1'b1;
          load_pos_nxt = cnt_dec[POS_W-1:0];
          slice_nxt    = fresh;
          wr_en        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // totals and per-task flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qmark_r <= '0;
      wvld_r  <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (state_r == S_LOOK) begin
      total_r <= total_nxt;
      count_r <= count_nxt;
      if (qset) begin
        qmark_r[task_r] <= 1'b1;
      end else if (qclr) begin
        qmark_r[task_r] <= 1'b0;
      end
      if (wr_en) begin
        wvld_r[task_r] <= 1'b1;
      end
    end
  end

  // transaction payload and step plan
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_tuser;
      task_r <= in_tdata[IN_TASK_LO +: ID_W];
      fg_r   <= in_tdata[IN_FG_BIT];
    end
    if (state_r == S_LOOK) begin
      status_r   <= status_nxt;
      resched_r  <= resched_nxt;
      shift_r    <= shift_nxt;
      load_r     <= load_nxt;
      load_pos_r <= load_pos_nxt;
      pos_r      <= match_pos;
      slice_r    <= slice_nxt;
    end
  end

  // ---------------------------------------------------------------- queue row
  always_comb begin
    ctl.match_en = in_accept;
    ctl.cmp_id   = in_tdata[IN_TASK_LO +: ID_W];
    ctl.count    = count_r;
    ctl.shift_en = (state_r == S_EXEC) && shift_r;
    ctl.pos      = pos_r;
    ctl.load_en  = (state_r == S_EXEC) && load_r;
    ctl.load_pos = load_pos_r;
    ctl.load_id  = task_r;
  end

  wrq_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .head_id   (head_id),
    .match_pos (match_pos)
  );

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {
        {OUT_PAD_W{1'b0}},
        slice_r,
        count_r,
        total_r,
        (count_r != '0) ? head_id : {ID_W{1'b0}},
        (count_r != '0),
        resched_r,
        status_r
      };
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/wrq_ram.sv =====
// generic single-port-write, registered-read memory
// no dependencies
module wrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/wrq_cell.sv =====
// one queue slot: holds a task id, matches it and shifts from its right neighbor
// depends on wrq_pkg
module wrq_cell
  import wrq_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [POS_W-1:0] idx,
  input  logic [ID_W-1:0]  nbr_id,
  output logic [ID_W-1:0]  slot_id,
  output logic             match
);

  logic [ID_W-1:0] slot_id_r;
  logic            match_r;
  logic            occupied;

  assign occupied = {1'b0, idx} < ctl.count;

  always_ff @(posedge clk) begin
    // a load at this slot wins over the shift of a rotate
    if (ctl.load_en && (idx == ctl.load_pos)) begin
      slot_id_r <= ctl.load_id;
    end else if (ctl.shift_en && (idx >= ctl.pos)) begin
      slot_id_r <= nbr_id;
    end
    if (ctl.match_en) begin
      match_r <= occupied && (slot_id_r == ctl.cmp_id);
    end
  end

  assign slot_id = slot_id_r;
  assign match   = match_r;

endmodule

// ===== design/wrq_chain.sv =====
// row of queue cells in order from head to tail, plus the match position encoder
// depends on wrq_pkg, wrq_cell
module wrq_chain
  import wrq_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  output logic [ID_W-1:0]  head_id,
  output logic [POS_W-1:0] match_pos
);

  logic [ID_W-1:0]      slot_ids [MAX_TASKS];
  logic [ID_W-1:0]      nbr_ids  [MAX_TASKS];
  logic [MAX_TASKS-1:0] match_bits;

  for (genvar j = 0; j < MAX_TASKS; j++) begin : g_cell
    if (j == MAX_TASKS - 1) begin : g_last
      assign nbr_ids[j] = '0;
    end else begin : g_mid
      assign nbr_ids[j] = slot_ids[j+1];
    end

    wrq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (POS_W'(j)),
      .nbr_id  (nbr_ids[j]),
      .slot_id (slot_ids[j]),
      .match   (match_bits[j])
    );
  end

  // ids in the queue are unique, so at most one match bit is set
  always_comb begin
    match_pos = '0;
    for (int j = 0; j < MAX_TASKS; j++) begin
      if (match_bits[j]) begin
        match_pos = match_pos | POS_W'(j);
      end
    end
  end

  assign head_id = slot_ids[0];

endmodule

// ===== design/wrq_checker.sv =====
// port-level checks of the weighted round-robin run queue, bound to the top level
// depends on wrq_pkg and weighted_rr_run_queue_defines.svh
`include "weighted_rr_run_queue_defines.svh"

module wrq_checker
  import wrq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  `WRQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid,
    "result valid right after reset")

  `WRQ_ASSERT_CLK(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
    "stalled result changed")

  `WRQ_ASSERT_CLK(a_count_range, clk, rst_n,
    out_tvalid |-> out_tdata[OUT_CNT_LO +: CNT_W] <= CNT_W'(MAX_TASKS),
    "queued count above capacity")

  `WRQ_ASSERT_CLK(a_next_valid, clk, rst_n,
    out_tvalid |-> out_tdata[OUT_NVALID] == (out_tdata[OUT_CNT_LO +: CNT_W] != '0),
    "next_valid disagrees with queued count")

  `WRQ_ASSERT_CLK(a_resched_done, clk, rst_n,
    out_tvalid && out_tdata[OUT_RESCHED] |->
      out_tdata[OUT_STATUS_LO +: STATUS_W] == ST_DONE,
    "reschedule flagged on a rejected transaction")

endmodule

bind weighted_rr_run_queue wrq_checker u_wrq_checker (.*);
